// File: src/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants for the position PID controller
// Register indexes, reset values, datapath widths and the 32-bit saturation
// helper used by the controller state update.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TARGET    = 3'd0,
    CFG_GAIN_P    = 3'd1,
    CFG_GAIN_I    = 3'd2,
    CFG_GAIN_D    = 3'd3,
    CFG_THRESHOLD = 3'd4,
    CFG_LIMIT     = 3'd5,
    CFG_DIVIDER   = 3'd6
  } cfg_idx_e;

  // Register values after reset.
  localparam logic signed [31:0] TARGET_RST    = 32'sd250;
  localparam logic [15:0]        GAIN_P_RST    = 16'd1556;
  localparam logic [15:0]        GAIN_I_RST    = 16'd1638;
  localparam logic [15:0]        GAIN_D_RST    = 16'd717;
  localparam logic [15:0]        THRESHOLD_RST = 16'd50;
  localparam logic [14:0]        LIMIT_RST     = 15'd300;
  localparam logic [15:0]        DIVIDER_RST   = 16'd40;

  // Width of the gain sum: three products of 16-bit gains with at most
  // 33-bit operands, plus two bits of growth.
  localparam int ACC_W = 52;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Values of one update tick, handed from the state update to the
  // gain stages.
  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] error;
    logic signed [31:0] integral;
    logic signed [32:0] diff;
  } upd_t;

  // Controller gains and output clamp.
  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [14:0] limit;
  } gains_t;

  // Saturates a 33-bit signed value into the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? S32_MIN : S32_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/position_pid_integral_separation.sv
// ----------------------------------------------------------------------------
// position_pid_integral_separation: tick-driven positional PID controller
// Path: an accepted update tick passes the input, product and output registers.
// Throughput: one tick item per cycle while the result path does not stall.
// Reset: registers take their defaults, position, error and integral clear.
// ----------------------------------------------------------------------------
`default_nettype none

// Each accepted item is one timer tick. A tick counter divides the ticks, and
// only every divider-th tick is an update tick that yields a result; the
// other ticks just advance the counter. The controller state (position, last
// error and the error integral) is updated in the same cycle the item is
// accepted, so the next tick always sees the state left by this one. The
// values of an update tick then travel through a product stage and a sum and
// clamp stage in pps_law, which holds the output register. Ready is passed
// back stage by stage, so a waiting result stops ticks once the stages fill.
module position_pid_integral_separation #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] encoder_delta_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      drive_command_o,
  output logic signed [31:0]      position_now_o,
  output logic signed [31:0]      error_now_o
);

  // Configuration registers.
  logic signed [31:0] target_q;
  logic [15:0]        gain_p_q, gain_i_q, gain_d_q;
  logic [15:0]        threshold_q;
  logic [14:0]        limit_q;
  logic [15:0]        divider_q;

  // Controller state.
  logic [15:0]        tick_count_q;
  logic signed [31:0] position_q, last_error_q, integral_q;

  // Input register holding the values of one update tick.
  logic               upd_valid_q;
  pps_pkg::upd_t      upd_q;

  logic               upd_ready, in_fire, upd_tick;
  logic [15:0]        tick_inc;
  logic signed [32:0] pos_sum, err_sum, int_sum, diff_d;
  logic signed [31:0] pos_d, err_d, int_d;
  logic [32:0]        err_mag;
  logic               in_band;
  pps_pkg::gains_t    gains;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= pps_pkg::TARGET_RST;
      gain_p_q    <= pps_pkg::GAIN_P_RST;
      gain_i_q    <= pps_pkg::GAIN_I_RST;
      gain_d_q    <= pps_pkg::GAIN_D_RST;
      threshold_q <= pps_pkg::THRESHOLD_RST;
      limit_q     <= pps_pkg::LIMIT_RST;
      divider_q   <= pps_pkg::DIVIDER_RST;
    end else if (cfg_valid_i) begin
      // Writes to an index past the register list are dropped.
      case (cfg_index_i)
        pps_pkg::CFG_TARGET:    target_q    <= cfg_data_i;
        pps_pkg::CFG_GAIN_P:    gain_p_q    <= cfg_data_i[15:0];
        pps_pkg::CFG_GAIN_I:    gain_i_q    <= cfg_data_i[15:0];
        pps_pkg::CFG_GAIN_D:    gain_d_q    <= cfg_data_i[15:0];
        pps_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i[15:0];
        pps_pkg::CFG_LIMIT:     limit_q     <= cfg_data_i[14:0];
        pps_pkg::CFG_DIVIDER:   divider_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // The input register can load when it is empty or its item moves on.
  assign in_ready_o = !upd_valid_q || upd_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  // A divider of zero makes every tick an update tick, since the count
  // is never below zero.
  assign tick_inc = tick_count_q + 16'd1;
  assign upd_tick = (tick_inc >= divider_q);

  // State update: saturating position, saturating error, then the separated
  // integral, which only accumulates while the error magnitude is in band.
  always_comb begin
    pos_sum = 33'(position_q) + 33'(encoder_delta_i);
    pos_d   = pps_pkg::sat32(pos_sum);
    err_sum = 33'(target_q) - 33'(pos_d);
    err_d   = pps_pkg::sat32(err_sum);
    err_mag = err_d[31] ? 33'(-33'(err_d)) : 33'(err_d);
    in_band = (err_mag < {17'd0, threshold_q});
    int_sum = 33'(integral_q) + 33'(err_d);
    int_d   = in_band ? pps_pkg::sat32(int_sum) : 32'sd0;
    diff_d  = 33'(err_d) - 33'(last_error_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      position_q   <= '0;
      last_error_q <= '0;
      integral_q   <= '0;
      upd_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        upd_valid_q <= in_valid_i && upd_tick;
      end
      if (in_fire) begin
        tick_count_q <= upd_tick ? 16'd0 : tick_inc;
        if (upd_tick) begin
          position_q   <= pos_d;
          last_error_q <= err_d;
          integral_q   <= int_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && upd_tick) begin
      upd_q.position <= pos_d;
      upd_q.error    <= err_d;
      upd_q.integral <= int_d;
      upd_q.diff     <= diff_d;
    end
  end

  assign gains.gain_p = gain_p_q;
  assign gains.gain_i = gain_i_q;
  assign gains.gain_d = gain_d_q;
  assign gains.limit  = limit_q;

  pps_law #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_law (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_valid_i    (upd_valid_q),
    .upd_ready_o    (upd_ready),
    .upd_i          (upd_q),
    .gains_i        (gains),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_command_o(drive_command_o),
    .position_now_o (position_now_o),
    .error_now_o    (error_now_o)
  );

  // A tick that is not an update tick never creates a pending update.
  a_no_spurious_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !upd_tick) |=> !upd_valid_q)
    else $error("non-update tick produced an update");

  // The integral is cleared whenever the error leaves the band.
  a_integral_separation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && upd_tick && !in_band) |=> (integral_q == 32'sd0))
    else $error("integral not cleared outside the band");

  // The drive command never exceeds the configured limit in magnitude.
  a_drive_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((drive_command_o <= $signed({1'b0, limit_q}))
                  && (drive_command_o >= -$signed({1'b0, limit_q}))))
    else $error("drive command outside the output limit");

endmodule

`default_nettype wire

// File: src/pps_law.sv
// ----------------------------------------------------------------------------
// pps_law: gain multiply, sum, shift and clamp stages
// Two pipeline stages: the three gain products are registered, then summed,
// shifted to integer scale, clamped and negated into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_law #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 upd_valid_i,
  output logic                      upd_ready_o,
  input  wire pps_pkg::upd_t        upd_i,
  input  wire pps_pkg::gains_t      gains_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [15:0]        drive_command_o,
  output logic signed [31:0]        position_now_o,
  output logic signed [31:0]        error_now_o
);

  localparam int AW = pps_pkg::ACC_W;

  logic                      prod_valid_q;
  logic signed [48:0]        prod_p_q, prod_i_q;
  logic signed [49:0]        prod_d_q;
  logic signed [31:0]        pos2_q, err2_q;
  logic signed [48:0]        prod_p_d, prod_i_d;
  logic signed [49:0]        prod_d_d;

  logic                      out_valid_q;
  logic signed [15:0]        drive_q;
  logic signed [31:0]        pos3_q, err3_q;

  logic                      adv_out, ld_prod;
  logic signed [AW-1:0]      acc, shifted, lim_s, res;
  logic signed [AW-1:0]      neg_res;

  assign adv_out     = !out_valid_q || out_ready_i;
  assign ld_prod     = !prod_valid_q || adv_out;
  assign upd_ready_o = ld_prod;

  assign prod_p_d = $signed({1'b0, gains_i.gain_p}) * upd_i.error;
  assign prod_i_d = $signed({1'b0, gains_i.gain_i}) * upd_i.integral;
  assign prod_d_d = $signed({1'b0, gains_i.gain_d}) * upd_i.diff;

  // Arithmetic shift rounds toward minus infinity.
  always_comb begin
    acc     = AW'(prod_p_q) + AW'(prod_i_q) + AW'(prod_d_q);
    shifted = acc >>> GAIN_FRAC_BITS;
    lim_s   = $signed({{(AW-15){1'b0}}, gains_i.limit});
    if (shifted > lim_s) begin
      res = lim_s;
    end else if (shifted < -lim_s) begin
      res = -lim_s;
    end else begin
      res = shifted;
    end
    neg_res = -res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ld_prod) begin
        prod_valid_q <= upd_valid_i;
      end
      if (adv_out) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_prod && upd_valid_i) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
      pos2_q   <= upd_i.position;
      err2_q   <= upd_i.error;
    end
    if (adv_out && prod_valid_q) begin
      drive_q <= neg_res[15:0];
      pos3_q  <= pos2_q;
      err3_q  <= err2_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_command_o = drive_q;
  assign position_now_o  = pos3_q;
  assign error_now_o     = err3_q;

endmodule

`default_nettype wire

// File: tb/pps_drive_checker.sv
// ----------------------------------------------------------------------------
// pps_drive_checker: predicts and checks the position PID drive updates
// Watches the tick, register and result channels of the controller. It keeps
// its own copy of the registers and the controller state, predicts the result
// of every update tick, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_drive_checker #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic signed [15:0] encoder_delta_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [15:0] drive_command_i,
  input  wire logic signed [31:0] position_now_i,
  input  wire logic signed [31:0] error_now_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  import pps_pkg::*;

  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [31:0] position;
    logic signed [31:0] error;
  } drive_update_t;

  // Register copy.
  logic signed [31:0] target_pos;
  logic [15:0]        kp, ki, kd;
  logic [15:0]        sep_threshold;
  logic [14:0]        drive_limit;
  logic [15:0]        divider;

  // Controller state copy.
  logic [15:0]        tick_cnt;
  logic signed [31:0] pos_acc;
  logic signed [31:0] prev_err;
  logic signed [31:0] err_sum;

  drive_update_t      due_updates[$];
  drive_update_t      want, got;
  int unsigned        misses;

  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > longint'(S32_MAX)) begin
      return S32_MAX;
    end
    if (v < longint'(S32_MIN)) begin
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  // Advances the tick counter and, on an update tick, the controller state.
  function automatic void step_controller(input logic signed [15:0] delta);
    longint err, mag, acc, cmd, lim;
    drive_update_t upd;
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt < divider) begin
      return;
    end
    tick_cnt = '0;
    pos_acc  = clamp_s32(longint'(pos_acc) + longint'(delta));
    err      = longint'(clamp_s32(longint'(target_pos) - longint'(pos_acc)));
    mag      = (err < 0) ? -err : err;
    if (mag < longint'(sep_threshold)) begin
      err_sum = clamp_s32(longint'(err_sum) + err);
    end else begin
      err_sum = '0;
    end
    acc = longint'(kp) * err + longint'(ki) * longint'(err_sum)
        + longint'(kd) * (err - longint'(prev_err));
    cmd = acc >>> GAIN_FRAC_BITS;
    lim = longint'(drive_limit);
    if (cmd > lim) begin
      cmd = lim;
    end
    if (cmd < -lim) begin
      cmd = -lim;
    end
    prev_err      = err[31:0];
    upd.drive     = 16'(-cmd);
    upd.position  = pos_acc;
    upd.error     = err[31:0];
    due_updates.push_back(upd);
  endfunction

  function automatic void apply_write(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      CFG_TARGET:    target_pos    = data;
      CFG_GAIN_P:    kp            = data[15:0];
      CFG_GAIN_I:    ki            = data[15:0];
      CFG_GAIN_D:    kd            = data[15:0];
      CFG_THRESHOLD: sep_threshold = data[15:0];
      CFG_LIMIT:     drive_limit   = data[14:0];
      CFG_DIVIDER:   divider       = data[15:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_pos    = TARGET_RST;
      kp            = GAIN_P_RST;
      ki            = GAIN_I_RST;
      kd            = GAIN_D_RST;
      sep_threshold = THRESHOLD_RST;
      drive_limit   = LIMIT_RST;
      divider       = DIVIDER_RST;
      tick_cnt      = '0;
      pos_acc       = '0;
      prev_err      = '0;
      err_sum       = '0;
      misses        = 0;
      due_updates.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // A result leaving now can only belong to an earlier tick, so results
      // are matched before this edge's tick is predicted.
      if (out_valid_i && out_ready_i) begin
        got = {drive_command_i, position_now_i, error_now_i};
        if (due_updates.size() == 0) begin
          misses++;
          if (misses <= 10) begin
            $display("%0t: result with nothing expected: drive %0d position %0d error %0d",
                     $time, got.drive, got.position, got.error);
          end
        end else begin
          want = due_updates.pop_front();
          if (want !== got) begin
            misses++;
            if (misses <= 10) begin
              $display("%0t: mismatch (expected/actual) drive %0d/%0d position %0d/%0d error %0d/%0d",
                       $time, want.drive, got.drive, want.position, got.position,
                       want.error, got.error);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        apply_write(cfg_index_i, cfg_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        step_controller(encoder_delta_i);
      end
      fail_count_o <= misses;
      pending_o    <= due_updates.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the tick-driven position PID controller
// Drives timer ticks and register writes with random idling and output
// stalls, and leaves prediction and checking to pps_drive_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  import pps_pkg::*;

  localparam int          FRAC_BITS      = 12;
  // Index past the last register; writes to it must leave every register alone.
  localparam logic [2:0]  CFG_SPARE      = 3'd7;
  // Percentage of cycles in which a side idles or stalls.
  localparam int unsigned STALL_PCT      = 21;
  localparam int unsigned RANDOM_TICKS   = 1750;
  // The longest correct quiet spell is the post-drain pause or a run of random
  // stalls on one side. A spell without any handshake that reaches this limit
  // can only mean a hang.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic signed [15:0] encoder_delta_i = '0;
  logic               cfg_valid_i     = 1'b0;
  logic [2:0]         cfg_index_i     = '0;
  logic [31:0]        cfg_data_i      = '0;
  logic               out_ready_i     = 1'b0;
  logic               in_ready_o;
  logic               cfg_ready_o;
  logic               out_valid_o;
  logic signed [15:0] drive_command_o;
  logic signed [31:0] position_now_o;
  logic signed [31:0] error_now_o;

  int unsigned        fail_count;
  int unsigned        pending_cnt;

  // Run bookkeeping, updated from the handshakes.
  logic signed [31:0] last_pos     = '0;
  logic [15:0]        divider_now  = DIVIDER_RST;
  logic               steady_run   = 1'b0;
  int unsigned        ticks_sent   = 0;
  int unsigned        results_seen = 0;
  int unsigned        writes_done  = 0;
  int unsigned        quiet_cycles = 0;

  position_pid_integral_separation #(
    .GAIN_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .encoder_delta_i(encoder_delta_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_command_o(drive_command_o),
    .position_now_o (position_now_o),
    .error_now_o    (error_now_o)
  );

  pps_drive_checker #(
    .GAIN_FRAC_BITS(FRAC_BITS)
  ) checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .encoder_delta_i(encoder_delta_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_command_i(drive_command_o),
    .position_now_i (position_now_o),
    .error_now_i    (error_now_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_cnt)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The receiver stalls at random, except during the steady stretch where it
  // takes every result at once.
  always @(posedge clk_i) begin
    out_ready_i <= steady_run || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // Handshake bookkeeping and the watchdog. The last reported position is
  // kept so that new setpoints can be placed near the current position,
  // which is where the integral term actually does something.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      last_pos     <= position_now_o;
      results_seen <= results_seen + 1;
    end
    if (in_valid_i && in_ready_o) begin
      ticks_sent <= ticks_sent + 1;
    end
    if (cfg_valid_i && cfg_ready_o) begin
      writes_done <= writes_done + 1;
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results still due.",
               quiet_cycles, pending_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sends one tick. Valid stays up from one item to the next unless this
  // tick opens with an idle spell, in which case it drops for those cycles.
  task automatic send_tick(input logic signed [15:0] delta);
    if (!steady_run && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < STALL_PCT);
    end
    in_valid_i      <= 1'b1;
    encoder_delta_i <= delta;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Writes one register. Only called while the controller is idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_DIVIDER) begin
      divider_now = data[15:0];
    end
    @(posedge clk_i);
  endtask

  // Holds the ticks back until every predicted result has arrived, then pauses
  // before returning: a non-update tick produces no result, and the result path
  // runs through the input, product and output registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Encoder deltas: mostly small motion so the loop can settle near the
  // setpoint, with full-range values and both extremes mixed in.
  function automatic logic signed [15:0] rand_delta();
    logic signed [15:0] d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: d = 16'($urandom_range(0, 32) - 16);
      6, 7:             d = 16'($urandom);
      8:                d = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default:          d = '0;
    endcase
    return d;
  endfunction

  // Picks write data for one register. Bits above the register's width stay
  // random, since the block must drop them.
  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    logic [31:0] data;
    int unsigned roll;
    data = $urandom;
    roll = $urandom_range(0, 9);
    case (idx)
      CFG_TARGET: begin
        case (roll)
          0:       data = S32_MAX;
          1:       data = S32_MIN;
          2:       ;
          default: data = last_pos + $urandom_range(0, 400) - 200;
        endcase
      end
      CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D: begin
        case (roll)
          0:       data[15:0] = '0;
          1:       data[15:0] = 16'hffff;
          2, 3:    ;
          default: data[15:0] = 16'($urandom_range(0, 8191));
        endcase
      end
      CFG_THRESHOLD: begin
        case (roll)
          0:       data[15:0] = '0;
          1:       data[15:0] = 16'hffff;
          2:       ;
          default: data[15:0] = 16'($urandom_range(16, 2000));
        endcase
      end
      CFG_LIMIT: begin
        case (roll)
          0:       data[14:0] = '0;
          1:       data[14:0] = 15'h7fff;
          2, 3, 4: ;
          default: data[14:0] = 15'($urandom_range(50, 3000));
        endcase
      end
      CFG_DIVIDER: begin
        case (roll)
          0:       data[15:0] = '0;
          1:       data[15:0] = 16'hffff;
          2, 3:    data[15:0] = 16'($urandom_range(5, 64));
          default: data[15:0] = 16'($urandom_range(1, 4));
        endcase
      end
      default: ;
    endcase
    return data;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned burst;
    int unsigned random_ticks;

    phase        = 0;
    random_ticks = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. First an update on every tick with the other registers
    // still at their reset values.
    write_reg(CFG_DIVIDER, 32'd1);
    send_tick(16'sd0);
    send_tick(16'sd7);
    send_tick(-16'sd7);

    // Full gains, widest clamp and a threshold wide enough that the large
    // errors below still feed the integral; deltas at both extremes.
    drain();
    write_reg(CFG_THRESHOLD, 32'h0000_ffff);
    write_reg(CFG_GAIN_P, 32'h0000_ffff);
    write_reg(CFG_GAIN_I, 32'h0000_ffff);
    write_reg(CFG_GAIN_D, 32'h0000_ffff);
    write_reg(CFG_LIMIT, 32'h0000_7fff);
    send_tick(16'sh7fff);
    send_tick(16'sh7fff);
    send_tick(16'sh8000);
    send_tick(-16'sd1);
    send_tick(16'sd1);

    // Setpoint at the top of the range with the position negative: the error
    // saturates high. Then the bottom of the range with a positive position:
    // it saturates low.
    drain();
    write_reg(CFG_TARGET, S32_MAX);
    send_tick(16'sh8000);
    send_tick(16'sh8000);
    drain();
    write_reg(CFG_TARGET, S32_MIN);
    repeat (4) send_tick(16'sh7fff);

    // A zero clamp forces the command to zero.
    drain();
    write_reg(CFG_LIMIT, 32'd0);
    send_tick(16'sd5);
    send_tick(-16'sd5);

    // A divider of zero makes every tick an update tick.
    drain();
    write_reg(CFG_LIMIT, 32'h0000_7fff);
    write_reg(CFG_DIVIDER, 32'd0);
    send_tick(16'sd3);
    send_tick(-16'sd3);
    send_tick(16'sd0);

    // A write past the last register must change nothing.
    drain();
    write_reg(CFG_SPARE, $urandom);
    send_tick(16'sd1);

    // Integral separation at its edge: an error equal to the threshold clears
    // the integral, one below it accumulates.
    drain();
    write_reg(CFG_TARGET, last_pos + 32'sd10);
    write_reg(CFG_THRESHOLD, 32'd10);
    write_reg(CFG_GAIN_P, 32'd4096);
    write_reg(CFG_GAIN_I, 32'd4096);
    write_reg(CFG_GAIN_D, 32'd4096);
    send_tick(16'sd0);
    drain();
    write_reg(CFG_THRESHOLD, 32'd11);
    send_tick(16'sd0);
    send_tick(16'sd0);

    // Zero gains give a zero command whatever the error.
    drain();
    write_reg(CFG_GAIN_P, 32'd0);
    write_reg(CFG_GAIN_I, 32'd0);
    write_reg(CFG_GAIN_D, 32'd0);
    send_tick(16'sd2);

    // Random part: phases of new register settings followed by a burst of
    // ticks. The divider is written every phase and kept small most of the
    // time so that results come often; a divider at its maximum gets only a
    // short burst, since no update will be reached within it.
    while (random_ticks < RANDOM_TICKS) begin
      drain();
      // Phases six through eight run without any idling on either side.
      steady_run <= (phase >= 6 && phase <= 8);
      for (int r = 0; r < 8; r++) begin
        if (r == CFG_DIVIDER || (r != CFG_SPARE && $urandom_range(0, 1) == 1) ||
            $urandom_range(0, 11) == 0) begin
          write_reg(3'(r), reg_value(3'(r)));
        end
      end
      burst = (divider_now == 16'hffff) ? 20 : $urandom_range(40, 120);
      for (int k = 0; k < burst; k++) begin
        // Once, hold the ticks back in mid-burst until every result is in.
        if (phase == 2 && k == burst / 2) begin
          drain();
        end
        send_tick(rand_delta());
        random_ticks++;
      end
      phase++;
    end
    drain();

    $display("Covered %0d ticks and %0d checked drive updates, with %0d register writes",
             ticks_sent, results_seen, writes_done);
    $display("over the directed settings and %0d random setting phases.", phase);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures, %0d results still due.", fail_count, pending_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: position_pid_integral_separation.f
src/pps_pkg.sv
src/pps_law.sv
src/position_pid_integral_separation.sv
tb/pps_drive_checker.sv
tb/tb.sv
